// ===== hdl/bpa_pkg.sv =====
// Bin packing allocator: shared types, sizes and helpers.
// Used by every module of the allocator; depends on nothing.
package bpa_pkg;

  localparam int MAX_BINS = 64;
  localparam int IDX_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W    = $clog2(MAX_BINS + 1);
  localparam int FILL_W   = 10;
  localparam int OUT_IDX_W = 6;

  localparam logic [FILL_W-1:0] CAP_RESET = FILL_W'(100);

  localparam logic CFG_FIT_MODE = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  typedef struct packed {
    logic [FILL_W-1:0] item_size;
    logic              start_set;
  } item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] bin_index;
    logic                 opened_new;
    logic [FILL_W-1:0]    new_fill;
    logic                 overflow;
  } result_t;

  // Search token walking the cell chain
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [IDX_W-1:0]  pick;
    logic [FILL_W-1:0] best_room;
    logic [FILL_W-1:0] fill;
  } tok_t;

  // Controller broadcast to all cells
  typedef struct packed {
    logic              clear;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [FILL_W-1:0] wr_fill;
    logic [FILL_W-1:0] size;
    logic [FILL_W-1:0] cap;
    logic              mode;
  } bcast_t;

  function automatic logic [OUT_IDX_W-1:0] low_index(input logic [IDX_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[OUT_IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/bpa_cell.sv =====
// One bin of the allocator chain: fill, open flag and one token stage.
// Depends on bpa_pkg.
module bpa_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [bpa_pkg::IDX_W-1:0]  idx,
  input  bpa_pkg::bcast_t            bc,
  input  bpa_pkg::tok_t              tok_in,
  output bpa_pkg::tok_t              tok_out
);
  import bpa_pkg::*;

  logic [FILL_W-1:0] fill;
  logic              open;
  tok_t              tok;
  tok_t              tok_next;
  logic [FILL_W:0]   total;
  logic [FILL_W-1:0] room;
  logic              fits;
  logic              take;

  always_comb begin
    total = {1'b0, fill} + {1'b0, bc.size};
    fits  = open && (total <= {1'b0, bc.cap});
    room  = bc.cap - total[FILL_W-1:0];
    take  = fits && (!tok_in.found || (bc.mode == FIT_BEST && room < tok_in.best_room));
    tok_next = tok_in;
    if (take) begin
      tok_next.found     = 1'b1;
      tok_next.pick      = idx;
      tok_next.best_room = room;
      tok_next.fill      = total[FILL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open <= 1'b0;
      tok  <= '0;
    end else begin
      tok <= tok_next;
      if (bc.clear) begin
        open <= 1'b0;
      end else if (bc.wr_en && bc.wr_idx == idx) begin
        open <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bc.wr_en && bc.wr_idx == idx) begin
      fill <= bc.wr_fill;
    end
  end

  assign tok_out = tok;

endmodule

// ===== hdl/bpa_chain.sv =====
// Row of MAX_BINS bin cells; the search token moves one cell per cycle.
// Depends on bpa_pkg and bpa_cell.
module bpa_chain (
  input  logic            clk,
  input  logic            rst,
  input  bpa_pkg::bcast_t bc,
  input  bpa_pkg::tok_t   head,
  output bpa_pkg::tok_t   tail
);
  import bpa_pkg::*;

  tok_t link [MAX_BINS+1];

  assign link[0] = head;

  for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
    bpa_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (IDX_W'(i)),
      .bc      (bc),
      .tok_in  (link[i]),
      .tok_out (link[i+1])
    );
  end

  assign tail = link[MAX_BINS];

endmodule

// ===== hdl/bpa_ctrl.sv =====
// Allocator sequencer: takes items, launches the search, commits the
// placement and holds the result register. Depends on bpa_pkg.
module bpa_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  bpa_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output bpa_pkg::result_t           result,
  input  logic                       mode,
  input  logic [bpa_pkg::FILL_W-1:0] cap,
  output bpa_pkg::bcast_t            bc,
  output bpa_pkg::tok_t              head,
  input  bpa_pkg::tok_t              tail
);
  import bpa_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LAUNCH = 2'd1;
  localparam logic [1:0] S_SWEEP  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [FILL_W-1:0] size;
  logic [CNT_W-1:0]  count;
  tok_t              res;
  logic              accept;
  logic              commit_go;
  logic              count_free;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign count_free = (count < CNT_W'(MAX_BINS));
  assign commit_go  = (state == S_COMMIT) && (!result_valid || !result_stall);

  always_comb begin
    bc.clear   = accept && item.start_set;
    bc.wr_en   = commit_go && (res.found || count_free);
    bc.wr_idx  = res.found ? res.pick : count[IDX_W-1:0];
    bc.wr_fill = res.found ? res.fill : size;
    bc.size    = size;
    bc.cap     = cap;
    bc.mode    = mode;
    head       = '0;
    head.valid = (state == S_LAUNCH);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_LAUNCH;
      S_LAUNCH: state_next = S_SWEEP;
      S_SWEEP:  if (tail.valid) state_next = S_COMMIT;
      S_COMMIT: if (commit_go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (bc.clear) begin
        count <= '0;
      end else if (commit_go && !res.found && count_free) begin
        count <= count + CNT_W'(1);
      end
      if (commit_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      size <= item.item_size;
    end
    if (state == S_SWEEP && tail.valid) begin
      res <= tail;
    end
    if (commit_go) begin
      if (res.found) begin
        result.bin_index  <= low_index(res.pick);
        result.opened_new <= 1'b0;
        result.new_fill   <= res.fill;
        result.overflow   <= 1'b0;
      end else if (count_free) begin
        result.bin_index  <= low_index(count[IDX_W-1:0]);
        result.opened_new <= 1'b1;
        result.new_fill   <= size;
        result.overflow   <= 1'b0;
      end else begin
        result.bin_index  <= '0;
        result.opened_new <= 1'b0;
        result.new_fill   <= '0;
        result.overflow   <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/bin_packing_allocator.sv =====
// Online first-fit / best-fit bin packing allocator, top level.
// Depends on bpa_pkg, bpa_ctrl, bpa_chain (bpa_cell).
//
//   channel   signals                               payload
//   item      item_valid / item_stall / item        bpa_pkg::item_t
//   result    result_valid / result_stall / result  bpa_pkg::result_t
//   config    cfg_we / cfg_index / cfg_data         fit_mode, bin_capacity
//
// One item at a time: the search token steps through one bin cell per cycle, then
// the placement is committed to the result register unless a held result stalls it.
// A held result does not block the next item transfer.
// Synchronous reset empties all bins and loads first fit, capacity 100.
module bin_packing_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  bpa_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output bpa_pkg::result_t           result,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bpa_pkg::FILL_W-1:0] cfg_data
);
  import bpa_pkg::*;

  logic              fit_mode;
  logic [FILL_W-1:0] bin_capacity;
  bcast_t            bc;
  tok_t              head;
  tok_t              tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode     <= FIT_FIRST;
      bin_capacity <= CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIT_MODE: fit_mode     <= cfg_data[0];
        CFG_CAPACITY: bin_capacity <= cfg_data;
        default:      ;
      endcase
    end
  end

  bpa_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mode         (fit_mode),
    .cap          (bin_capacity),
    .bc           (bc),
    .head         (head),
    .tail         (tail)
  );

  bpa_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .bc   (bc),
    .head (head),
    .tail (tail)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bin_packing_allocator: directed, overflow, random and
// backpressure tests against a built-in first-fit / best-fit placement predictor.
// Depends on bpa_pkg and the bin_packing_allocator RTL.
module testbench;
  import bpa_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int LONG_HOLD   = 400;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  logic    cfg_we;
  logic    cfg_index;
  logic [FILL_W-1:0] cfg_data;

  bin_packing_allocator i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Placement predictor state
  logic              fit_q;
  logic [FILL_W-1:0] cap_q;
  logic [FILL_W-1:0] fill_q [MAX_BINS];
  int unsigned       open_q;

  result_t pending_placements [$];
  int      mismatch_count;

  bit tx_idle;
  bit rx_idle;
  int rx_hold_req;
  int rx_hold_left;
  int rx_wait;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t place_item(input logic [FILL_W-1:0] size, input logic start);
    result_t           r;
    logic [FILL_W:0]   total;
    logic [FILL_W-1:0] room;
    logic [FILL_W-1:0] best_room;
    bit                found;
    int unsigned       pick;
    r = '0;
    found = 1'b0;
    pick = 0;
    best_room = '0;
    if (start) begin
      foreach (fill_q[i]) fill_q[i] = '0;
      open_q = 0;
    end
    for (int unsigned i = 0; i < open_q; i++) begin
      total = {1'b0, fill_q[i]} + {1'b0, size};
      if (total <= {1'b0, cap_q}) begin
        room = cap_q - total[FILL_W-1:0];
        if (!found || (fit_q == FIT_BEST && room < best_room)) begin
          found = 1'b1;
          pick = i;
          best_room = room;
          if (fit_q == FIT_FIRST) break;
        end
      end
    end
    if (found) begin
      fill_q[pick] = fill_q[pick] + size;
      r.bin_index = OUT_IDX_W'(pick);
      r.new_fill = fill_q[pick];
    end else if (open_q < MAX_BINS) begin
      fill_q[open_q] = size;
      r.bin_index = OUT_IDX_W'(open_q);
      r.opened_new = 1'b1;
      r.new_fill = size;
      open_q++;
    end else begin
      r.overflow = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [FILL_W-1:0] draw_size(input logic [FILL_W-1:0] cap);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return FILL_W'($urandom_range(0, cap / 3));
    if (sel < 75) return FILL_W'($urandom_range(0, cap));
    if (sel < 83) return cap;
    if (sel < 90) return '0;
    return FILL_W'($urandom_range(0, 1023));
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic drain_placements();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_placements.size() != 0);
  endtask

  task automatic offer_item(input logic [FILL_W-1:0] size, input logic start);
    int gap;
    bit pause;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    pause = tx_idle && ($urandom_range(0, 7) == 0);
    if (pause) begin
      drain_placements();
    end else if (gap > 0) begin
      item_valid <= 1'b0;
    end
    repeat (gap) @(posedge clk);
    item_valid <= 1'b1;
    item <= '{item_size: size, start_set: start};
    do @(posedge clk); while (item_stall);
    pending_placements.insert(pending_placements.size(), place_item(size, start));
  endtask

  task automatic write_reg(input logic idx, input logic [FILL_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_FIT_MODE) fit_q = value[0];
    else cap_q = value;
  endtask

  // Upper data bits of the mode write are junk on purpose
  task automatic configure(input logic mode, input logic [FILL_W-1:0] cap);
    logic [FILL_W-1:0] mode_word;
    mode_word = FILL_W'($urandom);
    mode_word[0] = mode;
    write_reg(CFG_FIT_MODE, mode_word);
    write_reg(CFG_CAPACITY, cap);
  endtask

  task automatic test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    // reset values: first fit, capacity 100; oversized bin, exact fill, zero size
    offer_item(10'd0, 1'b1);
    offer_item(10'd1023, 1'b0);
    offer_item(10'd100, 1'b0);
    offer_item(10'd0, 1'b0);
    offer_item(10'd50, 1'b0);
    offer_item(10'd30, 1'b0);
    offer_item(10'd25, 1'b0);
    offer_item(10'd20, 1'b0);
    drain_placements();
    configure(FIT_BEST, 10'd100);
    offer_item(10'd60, 1'b1);
    offer_item(10'd70, 1'b0);
    offer_item(10'd30, 1'b0);
    offer_item(10'd35, 1'b0);
    offer_item(10'd5, 1'b0);
    // equal room left in two bins: lowest index wins
    offer_item(10'd60, 1'b1);
    offer_item(10'd60, 1'b0);
    offer_item(10'd20, 1'b0);
    drain_placements();
    configure(FIT_FIRST, 10'd0);
    offer_item(10'd0, 1'b1);
    offer_item(10'd0, 1'b0);
    offer_item(10'd5, 1'b0);
    offer_item(10'd0, 1'b0);
    drain_placements();
    configure(FIT_FIRST, 10'd1023);
    offer_item(10'd1023, 1'b1);
    offer_item(10'd1, 1'b0);
    offer_item(10'd1022, 1'b0);
    drain_placements();
  endtask

  task automatic test_overflow();
    configure(FIT_FIRST, 10'd10);
    offer_item(10'd6, 1'b1);
    repeat (MAX_BINS - 1) offer_item(FILL_W'($urandom_range(6, 10)), 1'b0);
    repeat (3) offer_item(FILL_W'($urandom_range(6, 10)), 1'b0);
    offer_item(10'd1023, 1'b0);
    drain_placements();
    configure(FIT_BEST, 10'd10);
    offer_item(10'd7, 1'b0);
    offer_item(10'd0, 1'b0);
    offer_item(10'd5, 1'b1);
    drain_placements();
  endtask

  task automatic test_random_phases();
    logic              mode;
    logic [FILL_W-1:0] cap;
    for (int phase = 0; phase < 8; phase++) begin
      mode = (phase < 4) ? phase[0] : logic'($urandom_range(0, 1));
      if (phase == 0 || phase == 2) cap = 10'd1023;
      else if (phase == 1) cap = 10'd1;
      else if ($urandom_range(0, 3) == 0) cap = FILL_W'($urandom_range(1, 1023));
      else cap = FILL_W'($urandom_range(8, 150));
      configure(mode, cap);
      tx_idle = (phase % 3) != 2;
      rx_idle = (phase % 4) != 3;
      offer_item(draw_size(cap), 1'b1);
      repeat (77) offer_item(draw_size(cap), $urandom_range(0, 39) == 0);
      drain_placements();
    end
  endtask

  task automatic test_backpressure();
    configure(FIT_BEST, 10'd200);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_req = LONG_HOLD;
    offer_item(draw_size(10'd200), 1'b1);
    repeat (11) offer_item(draw_size(10'd200), 1'b0);
    drain_placements();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (8) offer_item(draw_size(10'd200), 1'b0);
    drain_placements();
  endtask

  // Result receiver: random stall per result, plus a long hold on request
  always @(posedge clk) begin : result_receiver
    bit xfer;
    xfer = result_valid && !result_stall;
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      result_stall <= 1'b1;
    end else if (xfer) begin
      rx_wait = rx_idle ? $urandom_range(0, 11) : 0;
      result_stall <= (rx_wait != 0);
    end else if (rx_wait > 0) begin
      if (result_valid) rx_wait--;
      result_stall <= (rx_wait != 0);
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_checker
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_placements.size() == 0) begin
        $display("%0t: result expected none actual bin %0d new %0d fill %0d ovf %0d",
                 $time, result.bin_index, result.opened_new, result.new_fill,
                 result.overflow);
        mismatch_count++;
      end else begin
        want = pending_placements.pop_front();
        compare_field("bin_index", 16'(want.bin_index), 16'(result.bin_index));
        compare_field("opened_new", 16'(want.opened_new), 16'(result.opened_new));
        compare_field("new_fill", 16'(want.new_fill), 16'(result.new_fill));
        compare_field("overflow", 16'(want.overflow), 16'(result.overflow));
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) stuck = 0;
      else stuck++;
    end
    $display("bin_packing_allocator regression: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FIT_MODE;
    cfg_data = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    rx_hold_req = 0;
    rx_hold_left = 0;
    rx_wait = 0;
    mismatch_count = 0;
    fit_q = FIT_FIRST;
    cap_q = CAP_RESET;
    foreach (fill_q[i]) fill_q[i] = '0;
    open_q = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_random_phases();
    test_backpressure();
    repeat (MAX_BINS + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_placements.size() == 0) begin
      $display("bin_packing_allocator regression: pass");
    end else begin
      $display("bin_packing_allocator regression: fail");
    end
    $finish;
  end

endmodule
